/* rtl/rtte_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rtte_pkg: shared types and constants for the RTT/RTO estimator
// Event codes, configuration register indexes, register reset values and the
// configuration bundle that travels from the register file to the datapath.
// ============================================================================
package rtte_pkg;

    // Event codes carried by the func field of a request
    typedef enum logic [1:0] {
        FUNC_NEW_PACKET = 2'd0,
        FUNC_ACK        = 2'd1,
        FUNC_TIMEOUT    = 2'd2,
        FUNC_REINIT     = 2'd3
    } func_e;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RTO_MIN      = 2'd0,
        CFG_RTO_MAX      = 2'd1,
        CFG_MAX_RETRANS  = 2'd2,
        CFG_INIT_RTTVAR  = 2'd3
    } cfg_index_e;

    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned RTT_W      = 20;
    localparam int unsigned RTO_MS_W   = 24;
    localparam int unsigned ALARM_W    = 15;

    // Register reset values
    localparam int unsigned RST_RTO_MIN_MS     = 2000;
    localparam int unsigned RST_RTO_MAX_MS     = 60000;
    localparam int unsigned RST_MAX_RETRANS    = 3;
    localparam int unsigned RST_INIT_RTTVAR_MS = 750;

    // Round to whole seconds: floor((ms + 500) / 1000) = floor(((ms+500)>>3) / 125).
    // The reciprocal below is exact for a 22-bit dividend.
    localparam int unsigned SEC_HALF_MS   = 500;
    localparam int unsigned SEC_DIV_IN_W  = 22;
    localparam int unsigned SEC_RECIP_W   = 23;
    localparam int unsigned SEC_RECIP_SH  = 29;
    localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = 23'd4294968;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [15:0]        rto_min_ms;
        logic [19:0]        rto_max_ms;
        logic [COUNT_W-1:0] max_retransmits;
        logic [15:0]        initial_rttvar_ms;
    } cfg_t;

endpackage

/* rtl/rtte_update.sv */
`timescale 1ns / 1ps
// ============================================================================
// rtte_update: next-state logic of the estimator
// Folds one event into the smoothed RTT, the deviation, the RTO and the
// retransmit count, and flags give-up on a timeout past the limit.
// ============================================================================
module rtte_update #(
    parameter int unsigned FRAC_BITS = 3
) (
    input  logic [1:0]                          func,
    input  logic [rtte_pkg::RTT_W-1:0]          rtt_ms,
    input  rtte_pkg::cfg_t                      cfg,
    input  logic [19+FRAC_BITS:0]               srtt,
    input  logic [19+FRAC_BITS:0]               dev,
    input  logic [23+FRAC_BITS:0]               rto,
    input  logic [rtte_pkg::COUNT_W-1:0]        count,
    output logic [19+FRAC_BITS:0]               srtt_next,
    output logic [19+FRAC_BITS:0]               dev_next,
    output logic [23+FRAC_BITS:0]               rto_next,
    output logic [rtte_pkg::COUNT_W-1:0]        count_next,
    output logic                                give_up
);

    localparam int unsigned EST_W = 20 + FRAC_BITS;
    localparam int unsigned RTO_W = 24 + FRAC_BITS;
    localparam int unsigned SUM_W = EST_W + 3;

    rtte_pkg::func_e           func_code;
    logic [EST_W-1:0]          meas;
    logic signed [EST_W:0]     delta;
    logic signed [EST_W:0]     srtt_full;
    logic [EST_W:0]            mag;
    logic signed [EST_W+1:0]   dev_diff;
    logic signed [EST_W+1:0]   dev_full;
    logic [EST_W-1:0]          srtt_ack;
    logic [EST_W-1:0]          dev_ack;
    logic [EST_W-1:0]          dev_init;
    logic [SUM_W-1:0]          rto_sum;
    logic [SUM_W-1:0]          lo_lim;
    logic [SUM_W-1:0]          hi_lim;
    logic [SUM_W-1:0]          rto_clamped;
    logic [rtte_pkg::COUNT_W:0] count_inc;

    assign func_code = rtte_pkg::func_e'(func);

    // Ack path: floor shifts of signed differences
    always_comb
    begin
        meas      = EST_W'(rtt_ms) << FRAC_BITS;
        delta     = $signed({1'b0, meas}) - $signed({1'b0, srtt});
        srtt_full = $signed({1'b0, srtt}) + (delta >>> 3);
        srtt_ack  = srtt_full[EST_W-1:0];
        mag       = delta[EST_W] ? (EST_W+1)'(-delta) : (EST_W+1)'(delta);
        dev_diff  = $signed({1'b0, mag}) - $signed({2'b00, dev});
        dev_full  = $signed({2'b00, dev}) + (dev_diff >>> 2);
        dev_ack   = dev_full[EST_W-1:0];
        dev_init  = EST_W'(cfg.initial_rttvar_ms) << FRAC_BITS;
    end

    // Clamp srtt + 4*dev; min wins over max
    always_comb
    begin
        if (func_code == rtte_pkg::FUNC_ACK)
            rto_sum = SUM_W'(srtt_ack) + {1'b0, dev_ack, 2'b00};
        else
            rto_sum = {1'b0, dev_init, 2'b00};
        lo_lim = SUM_W'(cfg.rto_min_ms) << FRAC_BITS;
        hi_lim = SUM_W'(cfg.rto_max_ms) << FRAC_BITS;
        if (rto_sum < lo_lim)
            rto_clamped = lo_lim;
        else if (rto_sum > hi_lim)
            rto_clamped = hi_lim;
        else
            rto_clamped = rto_sum;
    end

    // Select the next state by event
    always_comb
    begin
        srtt_next  = srtt;
        dev_next   = dev;
        rto_next   = rto;
        count_next = count;
        give_up    = 1'b0;
        count_inc  = {1'b0, count} + 1'b1;
        case (func_code)
            rtte_pkg::FUNC_NEW_PACKET:
            begin
                count_next = '0;
            end
            rtte_pkg::FUNC_ACK:
            begin
                srtt_next = srtt_ack;
                dev_next  = dev_ack;
                rto_next  = RTO_W'(rto_clamped);
            end
            rtte_pkg::FUNC_TIMEOUT:
            begin
                // Double the RTO, saturate at full scale
                rto_next   = rto[RTO_W-1] ? '1 : {rto[RTO_W-2:0], 1'b0};
                give_up    = count_inc > {1'b0, cfg.max_retransmits};
                count_next = count_inc[rtte_pkg::COUNT_W] ? '1
                                                          : count_inc[rtte_pkg::COUNT_W-1:0];
            end
            rtte_pkg::FUNC_REINIT:
            begin
                srtt_next = '0;
                dev_next  = dev_init;
                rto_next  = RTO_W'(rto_clamped);
            end
            default:
            begin
                count_next = count;
            end
        endcase
    end

endmodule

/* rtl/rtte_alarm.sv */
`timescale 1ns / 1ps
// ============================================================================
// rtte_alarm: RTO rounded to whole seconds
// Adds half a second and divides by 1000 through an exact reciprocal multiply.
// ============================================================================
module rtte_alarm (
    input  logic [rtte_pkg::RTO_MS_W-1:0] rto_ms,
    output logic [rtte_pkg::ALARM_W-1:0]  alarm_seconds
);

    localparam int unsigned SUM_W  = rtte_pkg::RTO_MS_W + 1;
    localparam int unsigned PROD_W = rtte_pkg::SEC_DIV_IN_W + rtte_pkg::SEC_RECIP_W;

    logic [SUM_W-1:0]                    rounded;
    logic [rtte_pkg::SEC_DIV_IN_W-1:0]   eighths;
    logic [PROD_W-1:0]                   prod;

    // Add half a second, drop the factor of 8, multiply by 1/125
    always_comb
    begin
        rounded       = SUM_W'(rto_ms) + SUM_W'(rtte_pkg::SEC_HALF_MS);
        eighths       = rounded[SUM_W-1:3];
        prod          = PROD_W'(eighths) * PROD_W'(rtte_pkg::SEC_RECIP);
        alarm_seconds = prod[rtte_pkg::SEC_RECIP_SH +: rtte_pkg::ALARM_W];
    end

endmodule

/* rtl/rtt_retransmit_timeout_estimator.sv */
`timescale 1ns / 1ps
// ============================================================================
// rtt_retransmit_timeout_estimator: Jacobson/Karels RTT and RTO estimator
// Three-stage request pipeline around the estimator state and a seconds
// rounding stage, with a write-only configuration register file.
// ============================================================================
// One request enters per cycle while in_ready is high, and its result is presented
// once it has passed the input register, the estimator update and the seconds
// rounding stage; the estimator state
// updates once per request as it leaves the input register, so back-to-back
// requests see each other's effect. Each request returns exactly one result
// describing the state after the event. Values are kept in milliseconds with
// FRAC_BITS fraction bits. Configuration writes take effect on the next
// request and do not move the stored RTO until an ack or reinit.
module rtt_retransmit_timeout_estimator #(
    parameter int unsigned FRAC_BITS = 3
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration
    input  logic                                   cfg_wr_en,
    input  logic [1:0]                             cfg_index,
    input  logic [rtte_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // Requests
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             func,
    input  logic [rtte_pkg::RTT_W-1:0]             rtt_ms,
    // Results
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [rtte_pkg::RTO_MS_W-1:0]          rto_ms,
    output logic [rtte_pkg::ALARM_W-1:0]           alarm_seconds,
    output logic                                   give_up,
    output logic [rtte_pkg::COUNT_W-1:0]           retransmit_count,
    output logic [19:0]                            smoothed_rtt_ms,
    output logic [19:0]                            deviation_ms
);

    localparam int unsigned EST_W = 20 + FRAC_BITS;
    localparam int unsigned RTO_W = 24 + FRAC_BITS;

    localparam int unsigned RST_RTO_RAW = 4 * rtte_pkg::RST_INIT_RTTVAR_MS;
    localparam int unsigned RST_RTO_MS  =
        (RST_RTO_RAW < rtte_pkg::RST_RTO_MIN_MS) ? rtte_pkg::RST_RTO_MIN_MS :
        (RST_RTO_RAW > rtte_pkg::RST_RTO_MAX_MS) ? rtte_pkg::RST_RTO_MAX_MS :
        RST_RTO_RAW;
    localparam logic [RTO_W-1:0] RST_RTO = RTO_W'(RST_RTO_MS) << FRAC_BITS;
    localparam logic [EST_W-1:0] RST_DEV =
        EST_W'(rtte_pkg::RST_INIT_RTTVAR_MS) << FRAC_BITS;

    rtte_pkg::cfg_t                cfg_reg;

    logic [EST_W-1:0]              srtt_reg;
    logic [EST_W-1:0]              dev_reg;
    logic [RTO_W-1:0]              rto_reg;
    logic [rtte_pkg::COUNT_W-1:0]  count_reg;

    logic [EST_W-1:0]              srtt_next;
    logic [EST_W-1:0]              dev_next;
    logic [RTO_W-1:0]              rto_next;
    logic [rtte_pkg::COUNT_W-1:0]  count_next;
    logic                          give_up_next;

    // Stage A: input register
    logic                          a_valid_reg;
    logic [1:0]                    a_func_reg;
    logic [rtte_pkg::RTT_W-1:0]    a_rtt_reg;

    // Stage B: updated state snapshot
    logic                          b_valid_reg;
    logic [rtte_pkg::RTO_MS_W-1:0] b_rto_ms_reg;
    logic                          b_give_up_reg;
    logic [rtte_pkg::COUNT_W-1:0]  b_count_reg;
    logic [19:0]                   b_srtt_ms_reg;
    logic [19:0]                   b_dev_ms_reg;

    // Stage C: result register
    logic                          c_valid_reg;
    logic [rtte_pkg::RTO_MS_W-1:0] c_rto_ms_reg;
    logic [rtte_pkg::ALARM_W-1:0]  c_alarm_reg;
    logic                          c_give_up_reg;
    logic [rtte_pkg::COUNT_W-1:0]  c_count_reg;
    logic [19:0]                   c_srtt_ms_reg;
    logic [19:0]                   c_dev_ms_reg;

    logic [rtte_pkg::ALARM_W-1:0]  alarm_next;
    logic                          adv_a;
    logic                          adv_b;
    logic                          adv_c;

    // Advance each stage when the next one is free or draining
    assign adv_c    = b_valid_reg && (!c_valid_reg || out_ready);
    assign adv_b    = a_valid_reg && (!b_valid_reg || adv_c);
    assign in_ready = !a_valid_reg || adv_b;
    assign adv_a    = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rto_min_ms        <= 16'(rtte_pkg::RST_RTO_MIN_MS);
            cfg_reg.rto_max_ms        <= 20'(rtte_pkg::RST_RTO_MAX_MS);
            cfg_reg.max_retransmits   <= rtte_pkg::COUNT_W'(rtte_pkg::RST_MAX_RETRANS);
            cfg_reg.initial_rttvar_ms <= 16'(rtte_pkg::RST_INIT_RTTVAR_MS);
        end
        else if (cfg_wr_en)
        begin
            case (rtte_pkg::cfg_index_e'(cfg_index))
                rtte_pkg::CFG_RTO_MIN:     cfg_reg.rto_min_ms        <= cfg_wdata[15:0];
                rtte_pkg::CFG_RTO_MAX:     cfg_reg.rto_max_ms        <= cfg_wdata[19:0];
                rtte_pkg::CFG_MAX_RETRANS: cfg_reg.max_retransmits   <= cfg_wdata[3:0];
                rtte_pkg::CFG_INIT_RTTVAR: cfg_reg.initial_rttvar_ms <= cfg_wdata[15:0];
                default:                   cfg_reg.rto_min_ms        <= cfg_reg.rto_min_ms;
            endcase
        end
    end

    rtte_update #(
        .FRAC_BITS (FRAC_BITS)
    ) u_update (
        .func       (a_func_reg),
        .rtt_ms     (a_rtt_reg),
        .cfg        (cfg_reg),
        .srtt       (srtt_reg),
        .dev        (dev_reg),
        .rto        (rto_reg),
        .count      (count_reg),
        .srtt_next  (srtt_next),
        .dev_next   (dev_next),
        .rto_next   (rto_next),
        .count_next (count_next),
        .give_up    (give_up_next)
    );

    rtte_alarm u_alarm (
        .rto_ms        (b_rto_ms_reg),
        .alarm_seconds (alarm_next)
    );

    // Control: valid flags and estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            srtt_reg    <= '0;
            dev_reg     <= RST_DEV;
            rto_reg     <= RST_RTO;
            count_reg   <= '0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (!b_valid_reg || adv_c)
                b_valid_reg <= a_valid_reg;
            if (!c_valid_reg || out_ready)
                c_valid_reg <= b_valid_reg;
            if (adv_b)
            begin
                srtt_reg  <= srtt_next;
                dev_reg   <= dev_next;
                rto_reg   <= rto_next;
                count_reg <= count_next;
            end
        end
    end

    // Payload: capture request, snapshot state, rounded result
    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_func_reg <= func;
            a_rtt_reg  <= rtt_ms;
        end
        if (adv_b)
        begin
            b_rto_ms_reg  <= rto_next[RTO_W-1:FRAC_BITS];
            b_give_up_reg <= give_up_next;
            b_count_reg   <= count_next;
            b_srtt_ms_reg <= srtt_next[EST_W-1:FRAC_BITS];
            b_dev_ms_reg  <= dev_next[EST_W-1:FRAC_BITS];
        end
        if (adv_c)
        begin
            c_rto_ms_reg  <= b_rto_ms_reg;
            c_alarm_reg   <= alarm_next;
            c_give_up_reg <= b_give_up_reg;
            c_count_reg   <= b_count_reg;
            c_srtt_ms_reg <= b_srtt_ms_reg;
            c_dev_ms_reg  <= b_dev_ms_reg;
        end
    end

    assign out_valid        = c_valid_reg;
    assign rto_ms           = c_rto_ms_reg;
    assign alarm_seconds    = c_alarm_reg;
    assign give_up          = c_give_up_reg;
    assign retransmit_count = c_count_reg;
    assign smoothed_rtt_ms  = c_srtt_ms_reg;
    assign deviation_ms     = c_dev_ms_reg;

    // Give-up only follows a timeout, which leaves a nonzero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && give_up) |-> (retransmit_count != '0))
        else $error("give_up raised with zero retransmit count");

    // Rounded seconds stay within half a second of the RTO
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((26'(alarm_seconds) * 26'd1000 <= 26'(rto_ms) + 26'd500) &&
                       (26'(rto_ms) + 26'd500 < 26'(alarm_seconds) * 26'd1000 + 26'd1000)))
        else $error("alarm_seconds does not match rto_ms");

    // A stalled result holds the stage behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !out_ready && b_valid_reg) |=> b_valid_reg)
        else $error("pending snapshot dropped under output stall");

endmodule

/* tb/rtt_retransmit_timeout_estimator_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// rtt_retransmit_timeout_estimator_tb: self-checking bench for the RTO estimator
// A bit-exact predictor of the estimator runs beside the DUT. Every request the
// DUT accepts is folded into the predictor, and each result the DUT returns is
// checked against the oldest prediction. Directed cases cover reset values,
// extreme RTT samples, timeout doubling and count saturation, and clamp order.
// They are followed by random packet traffic under several register settings,
// random idling on both sides, and a long receiver stall.
// ============================================================================
module rtt_retransmit_timeout_estimator_tb;

    localparam int unsigned FRAC     = 3;
    localparam int unsigned EST_W    = 20 + FRAC;
    localparam int unsigned RTO_W    = 24 + FRAC;
    localparam longint      RTO_SAT  = (64'd1 << RTO_W) - 1;
    localparam int unsigned SRTT_SH  = 3;   // smoothed RTT gain 1/8
    localparam int unsigned DEV_SH   = 2;   // deviation gain 1/4
    localparam int unsigned MAX_CNT  = 15;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned STALL_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [rtte_pkg::RTO_MS_W-1:0] rto_ms;
        logic [rtte_pkg::ALARM_W-1:0]  alarm_seconds;
        logic                          give_up;
        logic [rtte_pkg::COUNT_W-1:0]  retransmit_count;
        logic [19:0]                   smoothed_rtt_ms;
        logic [19:0]                   deviation_ms;
    } rto_result_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [1:0]                      cfg_index = rtte_pkg::CFG_RTO_MIN;
    logic [rtte_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [1:0]                      func = rtte_pkg::FUNC_NEW_PACKET;
    logic [rtte_pkg::RTT_W-1:0]      rtt_ms = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [rtte_pkg::RTO_MS_W-1:0]   rto_ms;
    logic [rtte_pkg::ALARM_W-1:0]    alarm_seconds;
    logic                            give_up;
    logic [rtte_pkg::COUNT_W-1:0]    retransmit_count;
    logic [19:0]                     smoothed_rtt_ms;
    logic [19:0]                     deviation_ms;

    // Predictor copy of the registers and estimator state
    logic [15:0]                  reg_rto_min;
    logic [19:0]                  reg_rto_max;
    logic [rtte_pkg::COUNT_W-1:0] reg_max_retx;
    logic [15:0]                  reg_init_dev;
    logic [EST_W-1:0]             est_srtt;
    logic [EST_W-1:0]             est_dev;
    logic [RTO_W-1:0]             est_rto;
    logic [rtte_pkg::COUNT_W-1:0] est_retries;

    rto_result_t pending_results[$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_left = 0;
    int unsigned setting_idx = 0;

    rtt_retransmit_timeout_estimator #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .rtt_ms           (rtt_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .rto_ms           (rto_ms),
        .alarm_seconds    (alarm_seconds),
        .give_up          (give_up),
        .retransmit_count (retransmit_count),
        .smoothed_rtt_ms  (smoothed_rtt_ms),
        .deviation_ms     (deviation_ms)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // Raise to the minimum first, otherwise lower to the maximum
    function automatic longint clamp_rto(longint value);
        longint lo;
        longint hi;
        lo = longint'(reg_rto_min) << FRAC;
        hi = longint'(reg_rto_max) << FRAC;
        if (value < lo)
            return lo;
        else if (value > hi)
            return hi;
        return value;
    endfunction

    function automatic void load_estimators();
        longint rto;
        est_srtt = '0;
        est_dev  = EST_W'(longint'(reg_init_dev) << FRAC);
        rto      = clamp_rto(longint'(est_srtt) + 4 * longint'(est_dev));
        est_rto  = RTO_W'(rto);
    endfunction

    function automatic void reset_estimator();
        reg_rto_min  = 16'(rtte_pkg::RST_RTO_MIN_MS);
        reg_rto_max  = 20'(rtte_pkg::RST_RTO_MAX_MS);
        reg_max_retx = rtte_pkg::COUNT_W'(rtte_pkg::RST_MAX_RETRANS);
        reg_init_dev = 16'(rtte_pkg::RST_INIT_RTTVAR_MS);
        est_retries  = '0;
        load_estimators();
    endfunction

    // Apply one event to the predicted state and return the result it causes
    function automatic rto_result_t apply_event(rtte_pkg::func_e ev,
                                                logic [rtte_pkg::RTT_W-1:0] rtt);
        rto_result_t res;
        longint      meas;
        longint      delta;
        longint      mag;
        longint      srtt_next;
        longint      dev_next;
        longint      rto;
        int unsigned retries_next;
        res = '0;
        case (ev)
            rtte_pkg::FUNC_NEW_PACKET:
            begin
                est_retries = '0;
            end
            rtte_pkg::FUNC_ACK:
            begin
                meas      = longint'(rtt) << FRAC;
                delta     = meas - longint'(est_srtt);
                srtt_next = longint'(est_srtt) + (delta >>> SRTT_SH);
                mag       = (delta < 0) ? -delta : delta;
                dev_next  = longint'(est_dev) + ((mag - longint'(est_dev)) >>> DEV_SH);
                est_srtt  = EST_W'(srtt_next);
                est_dev   = EST_W'(dev_next);
                rto       = clamp_rto(longint'(est_srtt) + 4 * longint'(est_dev));
                est_rto   = RTO_W'(rto);
            end
            rtte_pkg::FUNC_TIMEOUT:
            begin
                retries_next = est_retries + 1;
                rto = 2 * longint'(est_rto);
                if (rto > RTO_SAT)
                    rto = RTO_SAT;
                est_rto     = RTO_W'(rto);
                res.give_up = (retries_next > reg_max_retx);
                est_retries = (retries_next > MAX_CNT) ? rtte_pkg::COUNT_W'(MAX_CNT)
                                                       : rtte_pkg::COUNT_W'(retries_next);
            end
            default:
            begin
                load_estimators();
            end
        endcase
        res.rto_ms           = rtte_pkg::RTO_MS_W'(est_rto >> FRAC);
        res.alarm_seconds    = rtte_pkg::ALARM_W'(
            (longint'(est_rto) + (longint'(rtte_pkg::SEC_HALF_MS) << FRAC))
            / (longint'(1000) << FRAC));
        res.retransmit_count = est_retries;
        res.smoothed_rtt_ms  = 20'(est_srtt >> FRAC);
        res.deviation_ms     = 20'(est_dev >> FRAC);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offer one request, hold it until accepted, then predict its result
    task automatic send_request(rtte_pkg::func_e ev, logic [rtte_pkg::RTT_W-1:0] rtt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= ev;
        rtt_ms   <= rtt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_event(ev, rtt));
    endtask

    // Stop offering and wait for every predicted result to come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_register(rtte_pkg::cfg_index_e idx,
                                  logic [rtte_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            rtte_pkg::CFG_RTO_MIN:     reg_rto_min  = data[15:0];
            rtte_pkg::CFG_RTO_MAX:     reg_rto_max  = data[19:0];
            rtte_pkg::CFG_MAX_RETRANS: reg_max_retx = data[rtte_pkg::COUNT_W-1:0];
            rtte_pkg::CFG_INIT_RTTVAR: reg_init_dev = data[15:0];
            default:                   reg_rto_min  = reg_rto_min;
        endcase
    endtask

    // Write all four registers back to back; call only when the DUT is idle
    task automatic set_config(logic [rtte_pkg::CFG_DATA_W-1:0] min_ms,
                              logic [rtte_pkg::CFG_DATA_W-1:0] max_ms,
                              logic [rtte_pkg::CFG_DATA_W-1:0] retx,
                              logic [rtte_pkg::CFG_DATA_W-1:0] dev_ms);
        write_register(rtte_pkg::CFG_RTO_MIN, min_ms);
        write_register(rtte_pkg::CFG_RTO_MAX, max_ms);
        write_register(rtte_pkg::CFG_MAX_RETRANS, retx);
        write_register(rtte_pkg::CFG_INIT_RTTVAR, dev_ms);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly samples near a plausible RTT, sometimes near the estimate or extreme
    function automatic logic [rtte_pkg::RTT_W-1:0] pick_rtt();
        int unsigned r;
        int unsigned center;
        r = $urandom_range(99);
        center = est_srtt >> FRAC;
        if (r < 55)
            return rtte_pkg::RTT_W'($urandom_range(0, 3000));
        else if (r < 80)
            return rtte_pkg::RTT_W'(center + $urandom_range(0, 200) - 100);
        else if (r < 95)
            return rtte_pkg::RTT_W'($urandom);
        else if (r < 98)
            return '1;
        return '0;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random ready, long stall on demand, field-by-field check
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_checker
        rto_result_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: rto_ms %0d", rto_ms);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rto_ms !== want.rto_ms)
                begin
                    $error("rto_ms: expected %0d, actual %0d", want.rto_ms, rto_ms);
                    error_count++;
                end
                if (alarm_seconds !== want.alarm_seconds)
                begin
                    $error("alarm_seconds: expected %0d, actual %0d",
                           want.alarm_seconds, alarm_seconds);
                    error_count++;
                end
                if (give_up !== want.give_up)
                begin
                    $error("give_up: expected %0d, actual %0d", want.give_up, give_up);
                    error_count++;
                end
                if (retransmit_count !== want.retransmit_count)
                begin
                    $error("retransmit_count: expected %0d, actual %0d",
                           want.retransmit_count, retransmit_count);
                    error_count++;
                end
                if (smoothed_rtt_ms !== want.smoothed_rtt_ms)
                begin
                    $error("smoothed_rtt_ms: expected %0d, actual %0d",
                           want.smoothed_rtt_ms, smoothed_rtt_ms);
                    error_count++;
                end
                if (deviation_ms !== want.deviation_ms)
                begin
                    $error("deviation_ms: expected %0d, actual %0d",
                           want.deviation_ms, deviation_ms);
                    error_count++;
                end
            end
        end
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset values: new packet ignores its RTT, reinit reloads the defaults
    task automatic test_reset_values();
        send_request(rtte_pkg::FUNC_NEW_PACKET, '1);
        send_request(rtte_pkg::FUNC_REINIT, '0);
    endtask

    // Largest sample, then a zero sample for a large negative delta
    task automatic test_ack_extremes();
        send_request(rtte_pkg::FUNC_ACK, '1);
        send_request(rtte_pkg::FUNC_ACK, '0);
    endtask

    // Double the RTO into saturation, push the count to 15, keep it over reinit
    task automatic test_timeout_saturation();
        wait_idle();
        set_config(20'h0FFFF, 20'hFFFFF, 20'h0, 20'h0FFFF);
        send_request(rtte_pkg::FUNC_ACK, '1);
        repeat (MAX_CNT + 1)
            send_request(rtte_pkg::FUNC_TIMEOUT, rtte_pkg::RTT_W'($urandom));
        send_request(rtte_pkg::FUNC_REINIT, '0);
        send_request(rtte_pkg::FUNC_NEW_PACKET, '0);
    endtask

    // Minimum above maximum: small values go to the minimum, large to the maximum
    task automatic test_clamp_order();
        wait_idle();
        set_config(20'h0FFFF, 20'd100,
                   rtte_pkg::CFG_DATA_W'(rtte_pkg::RST_MAX_RETRANS), 20'h0);
        send_request(rtte_pkg::FUNC_REINIT, '0);
        send_request(rtte_pkg::FUNC_ACK, '0);
        send_request(rtte_pkg::FUNC_ACK, '1);
    endtask

    // Pick the next register setting, cycling through extremes and random ones
    task automatic next_setting();
        wait_idle();
        case (setting_idx % 6)
            0: set_config(rtte_pkg::CFG_DATA_W'(rtte_pkg::RST_RTO_MIN_MS),
                          rtte_pkg::CFG_DATA_W'(rtte_pkg::RST_RTO_MAX_MS),
                          rtte_pkg::CFG_DATA_W'(rtte_pkg::RST_MAX_RETRANS),
                          rtte_pkg::CFG_DATA_W'(rtte_pkg::RST_INIT_RTTVAR_MS));
            1: set_config('0, '0, '0, '0);
            2: set_config('1, '1, '1, '1);
            3: set_config({4'($urandom), 16'($urandom_range(0, 3000))},
                          rtte_pkg::CFG_DATA_W'($urandom_range(1000, 200000)),
                          {16'($urandom), 4'($urandom)},
                          {4'($urandom), 16'($urandom_range(0, 2000))});
            4: set_config(rtte_pkg::CFG_DATA_W'($urandom), rtte_pkg::CFG_DATA_W'($urandom),
                          rtte_pkg::CFG_DATA_W'($urandom), rtte_pkg::CFG_DATA_W'($urandom));
            default: set_config(rtte_pkg::CFG_DATA_W'($urandom_range(30000, 65535)),
                                rtte_pkg::CFG_DATA_W'($urandom_range(0, 20000)),
                                rtte_pkg::CFG_DATA_W'($urandom_range(0, 15)),
                                rtte_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
        endcase
        setting_idx++;
    endtask

    // Packets: start, a few timeouts, one or more acks; some stray events between
    task automatic test_random_traffic(int n_chunks, int chunk_items);
        int sent;
        int n_timeouts;
        repeat (n_chunks)
        begin
            next_setting();
            sent = 0;
            while (sent < chunk_items)
            begin
                if ($urandom_range(99) < 80)
                begin
                    send_request(rtte_pkg::FUNC_NEW_PACKET, rtte_pkg::RTT_W'($urandom));
                    n_timeouts = ($urandom_range(9) == 0) ? $urandom_range(5, 17)
                                                          : $urandom_range(0, 3);
                    repeat (n_timeouts)
                        send_request(rtte_pkg::FUNC_TIMEOUT, rtte_pkg::RTT_W'($urandom));
                    repeat ($urandom_range(1, 3))
                        send_request(rtte_pkg::FUNC_ACK, pick_rtt());
                    sent += n_timeouts + 2;
                end
                else
                begin
                    send_request(rtte_pkg::func_e'($urandom_range(0, 3)),
                                 rtte_pkg::RTT_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // Hold off the result side while requests keep coming, so the DUT stalls input
    task automatic test_backpressure();
        wait_idle();
        stall_left = STALL_CYCLES;
        repeat (40)
        begin
            if ($urandom_range(3) == 0)
                send_request(rtte_pkg::FUNC_TIMEOUT, rtte_pkg::RTT_W'($urandom));
            else
                send_request(rtte_pkg::FUNC_ACK, pick_rtt());
        end
        wait_idle();
    endtask

    initial
    begin
        reset_estimator();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 15;
        recv_idle_pct = 47;
        test_reset_values();
        test_ack_extremes();
        test_timeout_saturation();
        test_clamp_order();
        test_random_traffic(7, 65);

        send_idle_pct = 47;
        recv_idle_pct = 15;
        test_random_traffic(7, 65);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_traffic(7, 65);

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
rtl/rtte_pkg.sv
rtl/rtte_update.sv
rtl/rtte_alarm.sv
rtl/rtt_retransmit_timeout_estimator.sv
tb/rtt_retransmit_timeout_estimator_tb.sv
